@@ rtl/mrmt_pkg.sv @@
// shared types, constants and helpers for the multi-rate media timebase
// no dependencies; compiled first

package mrmt_pkg;

  localparam int unsigned RATE_W       = 24;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned CLK_SEL_W    = 3;
  localparam int unsigned NUM_CLOCKS_DEF = 8;
  localparam logic [RATE_W-1:0] MASTER_RATE_RST = 24'd90000;

  typedef enum logic [1:0] {
    ACT_ADVANCE  = 2'd0,
    ACT_SET_RATE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_CONVERT  = 2'd3
  } action_e;

  // one derived clock as kept in the table memory
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [WORD_W-1:0]  offset;
  } entry_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [SHIFT_W-1:0] msb;
  } div_status_t;

  // 32-bit window of the 64-bit master count, shifted right by s
  function automatic logic [WORD_W-1:0] count_window(input logic [WORD_W-1:0]  lo,
                                                     input logic [WORD_W-1:0]  hi,
                                                     input logic [SHIFT_W-1:0] s);
    logic [2*WORD_W-1:0] w;
    w = {hi, lo} >> s;
    return w[WORD_W-1:0];
  endfunction

endpackage

@@ rtl/mrmt_if.sv @@
// valid/ready stream interfaces for the timebase request and result channels
// depends on mrmt_pkg

interface mrmt_in_if
  import mrmt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [CLK_SEL_W-1:0] clock_sel;
  logic [CLK_SEL_W-1:0] target_clock;
  logic [RATE_W-1:0]    rate;
  logic [WORD_W-1:0]    amount;

  modport source (output valid, action, clock_sel, target_clock, rate, amount, input ready);
  modport sink   (input valid, action, clock_sel, target_clock, rate, amount, output ready);
endinterface

interface mrmt_out_if
  import mrmt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              error;

  modport source (output valid, value, error, input ready);
  modport sink   (input valid, value, error, output ready);
endinterface

@@ rtl/multi_rate_media_timebase.sv @@
// top level of the multi-rate media timebase: sequencer, master count, clock table
// depends on mrmt_pkg, mrmt_if, mrmt_ram, mrmt_div

// The block keeps a 64-bit master tick count and a table of NUM_CLOCKS derived
// clocks (shift and offset each) in a small synchronous ram. It handles one
// request at a time and returns exactly one result per request. An advance and
// a set rate each wait on the bit-serial divider that forms master_rate / rate;
// a read and a convert wait on the ram's registered read data and its single
// read port (source then target entry). A bad rate or a clock index at or above
// NUM_CLOCKS gives error with value 0. A new request is taken as soon as the
// sequencer is idle, even while the previous result still waits in the output
// register. master_rate is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while no request is in flight, as the block does not enforce this.

module multi_rate_media_timebase
  import mrmt_pkg::*;
#(
  parameter int unsigned NUM_CLOCKS = NUM_CLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  mrmt_in_if.sink           in_if,
  mrmt_out_if.source        out_if
);

  localparam int unsigned AddrW = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;   // source entry arrives
  localparam logic [3:0] ST_RD2  = 4'd2;   // target entry arrives
  localparam logic [3:0] ST_DIV  = 4'd3;   // wait for divider
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_ADD  = 4'd5;
  localparam logic [3:0] ST_SR1  = 4'd6;
  localparam logic [3:0] ST_SR2  = 4'd7;
  localparam logic [3:0] ST_CV1  = 4'd8;
  localparam logic [3:0] ST_CV2  = 4'd9;
  localparam logic [3:0] ST_CV3  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]            state_q, state_d;
  action_e               act_q;
  logic [AddrW-1:0]      sel_addr_q, tgt_addr_q;
  logic [WORD_W-1:0]     amount_q;
  logic [RATE_W-1:0]     master_q;
  logic [WORD_W-1:0]     cnt_lo_q, cnt_hi_q;
  logic [NUM_CLOCKS-1:0] vld_q;
  logic                  vld_rd_q;
  entry_t                ent_a_q, ent_b_q;
  logic [WORD_W-1:0]     t_a_q, t_b_q, prod_q, diff_q;
  logic                  later_q;
  logic [WORD_W-1:0]     res_val_q;
  logic                  res_err_q;
  logic                  out_valid_q;
  logic [WORD_W-1:0]     out_val_q;
  logic                  out_err_q;

  // ------------------------------------------------------------------
  // request decode at the input transfer
  // ------------------------------------------------------------------
  action_e           in_act;
  logic              in_xfer;
  logic              bad_rate, bad_sel, bad_tgt, in_err;
  logic [31:0]       sel_ext, tgt_ext;
  logic [AddrW-1:0]  in_sel_addr, in_tgt_addr;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign in_act      = action_e'(in_if.action);
  assign sel_ext     = 32'(in_if.clock_sel);
  assign tgt_ext     = 32'(in_if.target_clock);
  assign in_sel_addr = sel_ext[AddrW-1:0];
  assign in_tgt_addr = tgt_ext[AddrW-1:0];
  assign bad_rate    = (in_if.rate == '0) || (in_if.rate > master_q);
  assign bad_sel     = sel_ext >= NUM_CLOCKS;
  assign bad_tgt     = tgt_ext >= NUM_CLOCKS;

  always_comb begin
    unique case (in_act)
      ACT_ADVANCE:  in_err = bad_rate;
      ACT_SET_RATE: in_err = bad_sel || bad_rate;
      ACT_READ:     in_err = bad_sel;
      ACT_CONVERT:  in_err = bad_sel || bad_tgt;
      default:      in_err = 1'b1;
    endcase
  end

  // ------------------------------------------------------------------
  // divider for master_rate / rate and its leading-one position
  // ------------------------------------------------------------------
  logic              div_start;
  logic [RATE_W-1:0] quotient;
  div_status_t       div_st;

  assign div_start = in_xfer && !in_err &&
                     ((in_act == ACT_ADVANCE) || (in_act == ACT_SET_RATE));

  mrmt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (master_q),
    .divisor_i  (in_if.rate),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  // ------------------------------------------------------------------
  // clock table memory; entries never written read as zero via valid bits
  // ------------------------------------------------------------------
  logic              ram_we;
  logic [AddrW-1:0]  ram_raddr;
  entry_t            ram_wdata, ram_rdata, rd_entry;

  // source entry is looked up at the transfer, target entry in the cycle after
  assign ram_raddr = (state_q == ST_IDLE) ? in_sel_addr : tgt_addr_q;
  assign ram_we    = (state_q == ST_SR2);
  assign ram_wdata.shift  = div_st.msb;
  assign ram_wdata.offset = t_a_q - t_b_q;
  assign rd_entry  = vld_rd_q ? ram_rdata : '0;

  mrmt_ram #(
    .Width ($bits(entry_t)),
    .Depth (NUM_CLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sel_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // datapath helpers
  // ------------------------------------------------------------------
  logic [WORD_W-1:0]        time_a, time_b, raw_new, lat_diff, shifted;
  logic [RATE_W+WORD_W-1:0] prod_full;
  logic [WORD_W:0]          sum;
  logic                     is_later;

  assign time_a    = count_window(cnt_lo_q, cnt_hi_q, ent_a_q.shift) + ent_a_q.offset;
  assign time_b    = count_window(cnt_lo_q, cnt_hi_q, ent_b_q.shift) + ent_b_q.offset;
  assign raw_new   = count_window(cnt_lo_q, cnt_hi_q, div_st.msb);
  assign prod_full = (RATE_W+WORD_W)'(quotient) * (RATE_W+WORD_W)'(amount_q);
  assign sum       = {1'b0, cnt_lo_q} + {1'b0, prod_q};
  // wrap-aware compare: amount is later when the forward distance is in (0, 2^31)
  assign lat_diff  = amount_q - t_a_q;
  assign is_later  = (lat_diff != '0) && !lat_diff[WORD_W-1];
  // rescale the distance by the shift difference (always below 32)
  assign shifted   = (ent_b_q.shift > ent_a_q.shift) ?
                     (diff_q >> (ent_b_q.shift - ent_a_q.shift)) :
                     (diff_q << (ent_a_q.shift - ent_b_q.shift));

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_err) begin
            state_d = ST_OUT;
          end else if (in_act == ACT_ADVANCE) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_RD1;
          end
        end
      end
      ST_RD1: begin
        unique case (act_q)
          ACT_SET_RATE: state_d = ST_DIV;
          ACT_CONVERT:  state_d = ST_RD2;
          default:      state_d = ST_OUT;
        endcase
      end
      ST_RD2:  state_d = ST_CV1;
      ST_DIV: begin
        if (div_st.done) begin
          state_d = (act_q == ACT_ADVANCE) ? ST_MUL : ST_SR1;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_OUT;
      ST_SR1:  state_d = ST_SR2;
      ST_SR2:  state_d = ST_OUT;
      ST_CV1:  state_d = ST_CV2;
      ST_CV2:  state_d = ST_CV3;
      ST_CV3:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, master count, config register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      master_q    <= MASTER_RATE_RST;
      cnt_lo_q    <= '0;
      cnt_hi_q    <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        master_q <= cfg_wdata_i;
      end
      if (state_q == ST_ADD) begin
        cnt_lo_q <= sum[WORD_W-1:0];
        cnt_hi_q <= cnt_hi_q + WORD_W'(sum[WORD_W]);
      end
      if (ram_we) begin
        vld_q[sel_addr_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vld_rd_q <= vld_q[ram_raddr];
    if (in_xfer) begin
      act_q      <= in_act;
      sel_addr_q <= in_sel_addr;
      tgt_addr_q <= in_tgt_addr;
      amount_q   <= in_if.amount;
      res_val_q  <= '0;
      res_err_q  <= in_err;
    end
    unique case (state_q)
      ST_RD1: begin
        ent_a_q <= rd_entry;
        if (act_q == ACT_READ) begin
          res_val_q <= count_window(cnt_lo_q, cnt_hi_q, rd_entry.shift) + rd_entry.offset;
        end
      end
      ST_RD2:  ent_b_q <= rd_entry;
      ST_MUL:  prod_q  <= prod_full[WORD_W-1:0];
      ST_SR1: begin
        // old reading, and the raw window under the new shift
        t_a_q <= time_a;
        t_b_q <= raw_new;
      end
      ST_SR2:  res_val_q <= t_a_q;
      ST_CV1: begin
        t_a_q <= time_a;
        t_b_q <= time_b;
      end
      ST_CV2: begin
        later_q <= is_later;
        diff_q  <= is_later ? lat_diff : (t_a_q - amount_q);
      end
      ST_CV3:  res_val_q <= later_q ? (t_b_q + shifted) : (t_b_q - shifted);
      default: ;
    endcase
    if (out_load) begin
      out_val_q <= res_val_q;
      out_err_q <= res_err_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.value = out_val_q;
  assign out_if.error = out_err_q;

endmodule

@@ rtl/mrmt_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module mrmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mrmt_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle, msb first
// also reports the position of the leading quotient one; depends on mrmt_pkg

module mrmt_div
  import mrmt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic [RATE_W-1:0] quotient_o,
  output div_status_t       status_o
);

  localparam logic [SHIFT_W-1:0] LAST = SHIFT_W'(RATE_W - 1);

  logic               busy_q, done_q, found_q;
  logic [SHIFT_W-1:0] cnt_q, msb_q;
  logic [RATE_W-1:0]  rem_q, dvd_q, dsr_q, quo_q;

  logic [RATE_W:0]    trial;
  logic               ge;

  assign trial = {rem_q, dvd_q[RATE_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        found_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        if (ge) begin
          found_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      msb_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? RATE_W'(trial - {1'b0, dsr_q}) : trial[RATE_W-1:0];
      dvd_q <= {dvd_q[RATE_W-2:0], 1'b0};
      quo_q <= {quo_q[RATE_W-2:0], ge};
      if (ge && !found_q) begin
        msb_q <= LAST - cnt_q;
      end
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.done = done_q;
  assign status_o.msb  = msb_q;

endmodule
